// ===== rtl/core/nlc_pkg.sv =====
// shared types and constants for the numeric literal checker
// no dependencies; used by every module under rtl/core
package nlc_pkg;

  // character classes, also kept as the class of the previous character
  typedef enum logic [2:0] {
    CLS_START  = 3'd0,
    CLS_DIGIT  = 3'd1,
    CLS_EXP    = 3'd2,
    CLS_SIGN   = 3'd3,
    CLS_PERIOD = 3'd4,
    CLS_OTHER  = 3'd5
  } char_class_t;

  // position of the first exponent letter relative to the current character
  typedef enum logic [1:0] {
    EXP_NONE = 2'd0,
    EXP_LAST = 2'd1,
    EXP_PAST = 2'd2
  } exp_phase_t;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_LOW_E  = 8'h65;
  localparam logic [7:0] CHAR_UP_E   = 8'h45;
  localparam logic [7:0] CHAR_PERIOD = 8'h2e;
  localparam logic [7:0] CHAR_PLUS   = 8'h2b;
  localparam logic [7:0] CHAR_MINUS  = 8'h2d;

  localparam logic [7:0] MAX_LENGTH_RESET = 8'd50;
  localparam logic [7:0] COUNT_MAX        = 8'd255;

  // one classified item handed to the line tracker
  typedef struct packed {
    logic        eol;
    char_class_t cls;
  } item_t;

endpackage

// ===== rtl/core/numeric_literal_checker.sv =====
// top level of the numeric literal checker: input register, line tracker, result register
// depends on nlc_pkg, nlc_classify and nlc_line_state
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------
//   in      | in_valid / in_stall   | char_code, end_of_line
//   out     | out_valid / out_stall | is_valid
//   cfg     | cfg_valid / cfg_ready | cfg_data (max_length)
//
// one item per cycle is taken while in_stall is low; each character is checked in the cycle after it
// is registered, against the line state held in nlc_line_state
// a line's result is registered in the result register and shown on out_valid once its
// end-of-line item moves on from the input register
// reset clears the line state and loads max_length with 50; cfg_ready is always high
// in_stall rises only when an end-of-line item waits while a result is still stalled
module numeric_literal_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_valid,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic                 in_q_valid;
  logic [7:0]           char_q;
  logic                 eol_q;
  logic                 advance;
  logic                 step;
  logic                 line_ok;
  nlc_pkg::char_class_t cls;
  nlc_pkg::item_t       item;

  // the registered item may move on unless it is a line end facing a full, stalled result slot
  assign advance   = !eol_q || !out_valid || !out_stall;
  assign step      = in_q_valid && advance;
  assign in_stall  = in_q_valid && !advance;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      char_q <= char_code;
      eol_q  <= end_of_line;
    end
  end

  nlc_classify u_classify (
    .char_code (char_q),
    .cls       (cls)
  );

  assign item.eol = eol_q;
  assign item.cls = cls;

  nlc_line_state u_line_state (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .line_ok  (line_ok)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && eol_q) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && eol_q) begin
      is_valid <= line_ok;
    end
  end

  // a processed line end always leaves a result behind
  a_eol_gives_result: assert property (@(posedge clk) disable iff (rst)
    step && eol_q |=> out_valid)
    else $error("line end processed without a result");

  // a line end is held back while the previous result is stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && eol_q && out_valid && out_stall |-> in_stall && !step)
    else $error("result overwritten while stalled");

  // stall comes only from a waiting registered item
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid && eol_q && out_valid)
    else $error("input stalled without a waiting line end");

endmodule

// ===== rtl/core/nlc_classify.sv =====
// character classifier: maps a byte to its character class
// depends on nlc_pkg
module nlc_classify (
  input  logic [7:0]           char_code,
  output nlc_pkg::char_class_t cls
);

  // digit, exponent letter, sign, period or anything else
  always_comb begin
    if (char_code >= nlc_pkg::CHAR_ZERO && char_code <= nlc_pkg::CHAR_NINE) begin
      cls = nlc_pkg::CLS_DIGIT;
    end else if (char_code == nlc_pkg::CHAR_LOW_E || char_code == nlc_pkg::CHAR_UP_E) begin
      cls = nlc_pkg::CLS_EXP;
    end else if (char_code == nlc_pkg::CHAR_PLUS || char_code == nlc_pkg::CHAR_MINUS) begin
      cls = nlc_pkg::CLS_SIGN;
    end else if (char_code == nlc_pkg::CHAR_PERIOD) begin
      cls = nlc_pkg::CLS_PERIOD;
    end else begin
      cls = nlc_pkg::CLS_OTHER;
    end
  end

endmodule

// ===== rtl/core/nlc_line_state.sv =====
// line tracker: per-line state, rule checks and the max_length register
// depends on nlc_pkg
module nlc_line_state (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  nlc_pkg::item_t item,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_data,
  output logic           line_ok
);

  logic [7:0]           max_length;
  logic [7:0]           char_count;
  logic [7:0]           char_count_next;
  nlc_pkg::char_class_t previous_class;
  nlc_pkg::exp_phase_t  exponent_phase;
  nlc_pkg::exp_phase_t  exponent_phase_next;
  logic                 line_failed;
  logic                 char_fail;
  logic                 cls_special;

  // verdict for a line that ends now
  always_comb begin
    line_ok = !line_failed;
    if (char_count == 8'd0 || char_count > max_length) line_ok = 1'b0;
    if (previous_class == nlc_pkg::CLS_EXP || previous_class == nlc_pkg::CLS_SIGN)
      line_ok = 1'b0;
    if (char_count == 8'd1 && previous_class != nlc_pkg::CLS_DIGIT) line_ok = 1'b0;
  end

  // rules checked against each character
  assign cls_special = (item.cls == nlc_pkg::CLS_EXP) || (item.cls == nlc_pkg::CLS_SIGN) ||
                       (item.cls == nlc_pkg::CLS_PERIOD);

  always_comb begin
    char_fail = 1'b0;
    if (item.cls == nlc_pkg::CLS_OTHER) char_fail = 1'b1;
    if (item.cls == nlc_pkg::CLS_EXP && previous_class != nlc_pkg::CLS_DIGIT) char_fail = 1'b1;
    if (previous_class == nlc_pkg::CLS_EXP && item.cls != nlc_pkg::CLS_DIGIT &&
        item.cls != nlc_pkg::CLS_SIGN) char_fail = 1'b1;
    if (previous_class == nlc_pkg::CLS_SIGN && item.cls != nlc_pkg::CLS_DIGIT) char_fail = 1'b1;
    if (previous_class == nlc_pkg::CLS_PERIOD && cls_special) char_fail = 1'b1;
    if (exponent_phase == nlc_pkg::EXP_PAST && cls_special) char_fail = 1'b1;
    // an overlong line fails once a character arrives with the count already saturated
    if (char_count == nlc_pkg::COUNT_MAX) char_fail = 1'b1;
  end

  // exponent phase and saturating count
  always_comb begin
    exponent_phase_next = exponent_phase;
    case (exponent_phase)
      nlc_pkg::EXP_NONE: begin
        if (item.cls == nlc_pkg::CLS_EXP) exponent_phase_next = nlc_pkg::EXP_LAST;
      end
      nlc_pkg::EXP_LAST: exponent_phase_next = nlc_pkg::EXP_PAST;
      default:           exponent_phase_next = exponent_phase;
    endcase
    if (char_count == nlc_pkg::COUNT_MAX) char_count_next = char_count;
    else                                  char_count_next = char_count + 8'd1;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= nlc_pkg::MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      max_length <= cfg_data;
    end
  end

  // line state, cleared at each line end
  always_ff @(posedge clk) begin
    if (rst) begin
      char_count     <= 8'd0;
      previous_class <= nlc_pkg::CLS_START;
      exponent_phase <= nlc_pkg::EXP_NONE;
      line_failed    <= 1'b0;
    end else if (step) begin
      if (item.eol) begin
        char_count     <= 8'd0;
        previous_class <= nlc_pkg::CLS_START;
        exponent_phase <= nlc_pkg::EXP_NONE;
        line_failed    <= 1'b0;
      end else begin
        char_count     <= char_count_next;
        previous_class <= item.cls;
        exponent_phase <= exponent_phase_next;
        line_failed    <= line_failed | char_fail;
      end
    end
  end

endmodule

// ===== bench/nlc_checker.sv =====
// checker for the numeric literal checker: tracks each line as it is taken in
// and compares every line verdict against its own prediction
// depends on nlc_pkg for the character class and exponent phase types
`timescale 1ns / 1ps

module nlc_checker
  import nlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_line,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       is_valid,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  // predicted line state and the length limit
  logic [7:0]  limit_len;
  logic [7:0]  line_len;
  char_class_t last_cls;
  exp_phase_t  exp_pos;
  logic        line_bad;

  logic verdicts_due[$];
  int   errors = 0;

  function automatic char_class_t kind_of(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return CLS_DIGIT;
    if (c == CHAR_LOW_E || c == CHAR_UP_E) return CLS_EXP;
    if (c == CHAR_PLUS || c == CHAR_MINUS) return CLS_SIGN;
    if (c == CHAR_PERIOD) return CLS_PERIOD;
    return CLS_OTHER;
  endfunction

  function automatic logic is_mark(input char_class_t k);
    return k == CLS_EXP || k == CLS_SIGN || k == CLS_PERIOD;
  endfunction

  task automatic clear_line();
    line_len = '0;
    last_cls = CLS_START;
    exp_pos  = EXP_NONE;
    line_bad = 1'b0;
  endtask

  // apply the placement rules for one character of the line
  task automatic scan_char(input logic [7:0] c);
    char_class_t k;
    logic        bad;
    k   = kind_of(c);
    bad = (k == CLS_OTHER);
    if (k == CLS_EXP && last_cls != CLS_DIGIT) bad = 1'b1;
    if (last_cls == CLS_EXP && k != CLS_DIGIT && k != CLS_SIGN) bad = 1'b1;
    if (last_cls == CLS_SIGN && k != CLS_DIGIT) bad = 1'b1;
    if (last_cls == CLS_PERIOD && is_mark(k)) bad = 1'b1;
    if (exp_pos == EXP_PAST && is_mark(k)) bad = 1'b1;
    if (exp_pos == EXP_LAST)
      exp_pos = EXP_PAST;
    else if (exp_pos == EXP_NONE && k == CLS_EXP)
      exp_pos = EXP_LAST;
    // a line that would pass the counter's top is failed outright
    if (line_len == COUNT_MAX)
      bad = 1'b1;
    else
      line_len = line_len + 8'd1;
    if (bad) line_bad = 1'b1;
    last_cls = k;
  endtask

  // verdict for the finished line, then start afresh
  task automatic close_line(output logic ok);
    ok = !line_bad;
    if (line_len == 8'd0 || line_len > limit_len) ok = 1'b0;
    if (last_cls == CLS_EXP || last_cls == CLS_SIGN) ok = 1'b0;
    if (line_len == 8'd1 && last_cls != CLS_DIGIT) ok = 1'b0;
    clear_line();
  endtask

  // watch all three channels at each rising edge
  always @(posedge clk) begin : watch
    logic want;
    if (rst) begin
      limit_len = MAX_LENGTH_RESET;
      clear_line();
      verdicts_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected verdict, expected none, actual is_valid=%0b",
                   $time, is_valid);
        end else begin
          want = verdicts_due.pop_front();
          if (is_valid !== want) begin
            errors++;
            $display("%0t: verdict mismatch, expected is_valid=%0b, actual is_valid=%0b",
                     $time, want, is_valid);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (end_of_line) begin
          close_line(want);
          verdicts_due.push_back(want);
        end else begin
          scan_char(char_code);
        end
      end
      if (cfg_valid && cfg_ready) limit_len = cfg_data;
    end
    fail_count <= errors;
    pending    <= verdicts_due.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// top of the numeric literal checker testbench: clock, reset, line stimulus,
// result stalls, length limit writes and the verdict
// depends on nlc_pkg, numeric_literal_checker and nlc_checker
`timescale 1ns / 1ps

module tb_top;
  import nlc_pkg::*;

  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_code = 8'd0;
  logic       end_of_line = 1'b0;
  logic       out_valid;
  logic       out_stall;
  logic       is_valid;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  logic rx_stall = 1'b0;
  logic hold_off = 1'b0;
  logic no_gaps  = 1'b0;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  int   cur_max = MAX_LENGTH_RESET;

  logic [7:0] line_buf[$];
  event       hold_go;

  assign out_stall = rx_stall | hold_off;

  numeric_literal_checker DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .end_of_line(end_of_line),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_valid   (is_valid),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  nlc_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .end_of_line(end_of_line),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_valid   (is_valid),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // stop the run if nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** numeric_literal_checker: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: a random stall, sometimes none, on each verdict, held until one is showing
  initial begin : receiver
    int pause;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      pause = no_gaps ? 0 : $urandom_range(0, 5);
      if (pause > 0) begin
        rx_stall = 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (pause) @(negedge clk);
        rx_stall = 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // long hold on the result side so the block backs up into its input
  initial begin : long_hold
    forever begin
      @(hold_go);
      @(negedge clk);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_off = 1'b0;
    end
  end

  // offer one item and wait until it is taken
  task automatic push_char(input logic [7:0] code, input logic eol);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    char_code   = code;
    end_of_line = eol;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // send the buffered line, closed by an end item with a junk character
  task automatic send_line();
    foreach (line_buf[i]) push_char(line_buf[i], 1'b0);
    push_char(8'($urandom_range(0, 255)), 1'b1);
    line_buf.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line();
  endtask

  task automatic add_digits(input int n);
    repeat (n) line_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
  endtask

  function automatic logic [7:0] pick_sign();
    return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
  endfunction

  // mostly literal characters, sometimes any byte at all
  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 5))
      0: return CHAR_PERIOD;
      1: return pick_sign();
      2: return $urandom_range(0, 1) ? CHAR_LOW_E : CHAR_UP_E;
      3: return CHAR_ZERO + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // build a random line: mostly well-formed literals, some damaged, some noise, some digit runs at or past the limit
  task automatic make_line();
    int mode;
    mode = $urandom_range(0, 9);
    if (cur_max <= 60 && $urandom_range(0, 24) == 0) begin
      add_digits(cur_max + $urandom_range(0, 1));
    end else if (mode < 8) begin
      if ($urandom_range(0, 2) == 0) line_buf.push_back(pick_sign());
      if (mode == 0) begin
        line_buf.push_back(CHAR_PERIOD);
        add_digits($urandom_range(1, 3));
      end else begin
        add_digits($urandom_range(1, 4));
        if ($urandom_range(0, 1)) begin
          line_buf.push_back(CHAR_PERIOD);
          if ($urandom_range(0, 3) != 0) add_digits($urandom_range(1, 3));
        end
      end
      if ($urandom_range(0, 1)) begin
        if (line_buf[$] == CHAR_PERIOD) add_digits(1);
        line_buf.push_back($urandom_range(0, 1) ? CHAR_LOW_E : CHAR_UP_E);
        if ($urandom_range(0, 1)) line_buf.push_back(pick_sign());
        add_digits($urandom_range(1, 3));
      end
      // damage one character or cut the tail off
      if (mode >= 6) begin
        if ($urandom_range(0, 1))
          line_buf[$urandom_range(0, line_buf.size() - 1)] = pick_noise();
        else
          line_buf.pop_back();
      end
    end else begin
      repeat ($urandom_range(0, 6)) line_buf.push_back(pick_noise());
    end
  endtask

  task automatic run_random(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 15) == 0) no_gaps = ~no_gaps;
      make_line();
      sent += line_buf.size() + 1;
      send_line();
    end
    no_gaps = 1'b0;
  endtask

  // let every verdict come out before touching the limit
  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(input int v);
    settle();
    cur_max   = v;
    cfg_data  = 8'(v);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // lines of digits right at the limit and one past it
  task automatic edge_lengths();
    add_digits(cur_max);
    send_line();
    add_digits(cur_max + 1);
    send_line();
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed lines at the reset limit
    send_text("");
    send_text("7");
    send_text("+");
    send_text(".");
    send_text("e5");
    send_text("1e");
    send_text("1e5");
    send_text("9E+0");
    send_text("1e-5");
    send_text(".e5");
    send_text("1e.5");
    send_text("1e5.");
    send_text("12e3e");
    send_text("+5");
    send_text("1+");
    send_text("+.5");
    send_text("1.5");
    send_text(".5");
    send_text("1.e5");
    send_text("1a2");
    line_buf.push_back(8'h00);
    send_line();
    line_buf.push_back(8'h31);
    line_buf.push_back(8'h80);
    send_line();
    line_buf.push_back(8'hff);
    send_line();
    edge_lengths();

    // shortest limit
    write_limit(1);
    edge_lengths();
    run_random(60);

    // longest limit, an overlong line and a long hold on the result side
    write_limit(255);
    edge_lengths();
    -> hold_go;
    run_random(100);

    write_limit($urandom_range(2, 60));
    edge_lengths();
    run_random(60);

    write_limit(50);
    run_random(60);

    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("** numeric_literal_checker: PASSED **");
    else
      $display("** numeric_literal_checker: FAILED **");
    $finish;
  end

endmodule
